@@ sv/snz_pkg.sv @@
// ----------------------------------------------------------------------------
// snz_pkg
// Shared constants and helpers for the 2D simplex noise pipeline.
// ----------------------------------------------------------------------------
package snz_pkg;

	localparam int unsigned COORD_FRAC_BITS_DEF = 16;
	localparam int unsigned OUT_FRAC_BITS_DEF   = 14;

	// Skew and unskew constants, scaled by 2^32; unskew also in Q2.30
	localparam logic signed [31:0] SKEW_Q32   = 32'sd1572067139;
	localparam logic [29:0]        UNSKEW_Q32 = 30'd907633386;
	localparam logic signed [31:0] UNSKEW_Q30 = 32'sd226908346;
	localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
	localparam logic [33:0]        HALF_Q30   = 34'd536870912;

	localparam int unsigned TABLE_AW = 8;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

	// Remainder mod 12 of a table byte: reciprocal estimate, then fix-up
	function automatic logic [3:0] mod12(input logic [7:0] v);
		logic [13:0] prod;
		logic [4:0]  q;
		logic signed [9:0] rem;
		prod = 14'(v) * 14'd43;
		q    = prod[13:9];
		rem  = $signed({2'b00, v}) - $signed(10'(q) * 10'd12);
		if (rem < 0) begin
			rem = rem + 10'sd12;
		end
		return rem[3:0];
	endfunction

	// Gradient dot product for gradient index k (0..11)
	function automatic logic signed [32:0] grad_dot(input logic [3:0] k,
			input logic signed [31:0] dx, input logic signed [31:0] dy);
		logic signed [32:0] ex;
		logic signed [32:0] ey;
		logic signed [32:0] gx;
		logic signed [32:0] gy;
		ex = 33'(dx);
		ey = 33'(dy);
		gx = '0;
		gy = '0;
		if (k < 4'd8) begin
			gx = k[0] ? -ex : ex;
		end
		if (k < 4'd4) begin
			gy = k[1] ? -ey : ey;
		end else if (k >= 4'd8) begin
			gy = k[0] ? -ey : ey;
		end
		return gx + gy;
	endfunction

endpackage

@@ sv/snz_corner.sv @@
// ----------------------------------------------------------------------------
// snz_corner
// Four-stage contribution of one simplex corner: radial falloff times the
// hashed gradient dot product.
// ----------------------------------------------------------------------------
module snz_corner (
	input  logic                clk,
	input  logic                en,
	input  logic signed [31:0]  dx,
	input  logic signed [31:0]  dy,
	input  logic [7:0]          perm_val,
	output logic signed [31:0]  term
);
	import snz_pkg::*;

	logic signed [63:0] r2;
	logic [33:0]        r_sh;
	logic [29:0]        t_c1, t2_c2, t4_c3;
	logic               neg_c1, neg_c2, neg_c3;
	logic signed [32:0] d_c1, d_c2, d_c3;
	logic [59:0]        tt, tt2;
	logic signed [63:0] prod;

	assign r2   = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
	assign r_sh = r2[63:30];
	assign tt   = 60'(t_c1) * 60'(t_c1);
	assign tt2  = 60'(t2_c2) * 60'(t2_c2);
	assign prod = $signed({34'd0, t4_c3}) * 64'(d_c3);

	always_ff @(posedge clk) begin
		if (en) begin
			// distance falloff and gradient pick
			neg_c1 <= r_sh > HALF_Q30;
			t_c1   <= 30'(HALF_Q30 - r_sh);
			d_c1   <= grad_dot(mod12(perm_val), dx, dy);
			// square
			t2_c2  <= tt[59:30];
			neg_c2 <= neg_c1;
			d_c2   <= d_c1;
			// fourth power
			t4_c3  <= tt2[59:30];
			neg_c3 <= neg_c2;
			d_c3   <= d_c2;
			// weight the dot product, drop corners outside the radius
			term   <= neg_c3 ? '0 : prod[61:30];
		end
	end

endmodule

@@ sv/simplex_noise_2d.sv @@
// ----------------------------------------------------------------------------
// simplex_noise_2d
// Pipelined 2D simplex noise evaluator with a loadable permutation table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries cmd plus payload. A load
//   transaction (cmd = load) writes table_value at table_index and yields no
//   result. An evaluate transaction (cmd = eval) takes signed fixed-point
//   x_coord/y_coord and yields one noise_value on the output channel
//   (out_valid/out_ready), signed with OUT_FRAC_BITS fraction bits, clamped.
//   Load the whole table before evaluating; unwritten entries read garbage.
//   Throughput: one evaluate per cycle while the receiver does not stall;
//   the eleven stages share one advance enable.
//   A load is held off until the pipeline holds no evaluate, so earlier
//   samples still see the old table; loads then go one per cycle.
//   The table is kept as five identical copies, one per lookup, each with
//   one registered read port, all written together.
//   Reset clears the stage valid bits only; the table keeps its contents.
//   When the receiver stalls, the whole pipeline holds and in_ready drops;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module simplex_noise_2d #(
	parameter int unsigned COORD_FRAC_BITS = snz_pkg::COORD_FRAC_BITS_DEF,
	parameter int unsigned OUT_FRAC_BITS   = snz_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [7:0]         table_index,
	input  logic [7:0]         table_value,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);
	import snz_pkg::*;

	localparam int unsigned NSTAGE  = 11;
	localparam int unsigned NCOPY   = 5;
	localparam int unsigned RND_SH  = 30 - OUT_FRAC_BITS;
	localparam logic signed [40:0] RND_C = 41'sd1 <<< (RND_SH - 1);
	localparam logic signed [40:0] HI_RAW = 41'sd1 <<< OUT_FRAC_BITS;
	localparam logic signed [40:0] HI_C = (HI_RAW > 41'sd32767) ? 41'sd32767 : HI_RAW;
	localparam logic signed [40:0] LO_C = (-HI_RAW < -41'sd32768) ? -41'sd32768 : -HI_RAW;

	logic [NSTAGE:1] vld_q;
	logic            en, busy, in_acc;

	// Advance all stages together unless the output is full and stalled
	assign en        = !vld_q[NSTAGE] || out_ready;
	assign busy      = |vld_q;
	assign in_ready  = en && ((cmd == CMD_EVAL) || !busy);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = vld_q[NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-1:1], in_acc && (cmd == CMD_EVAL)};
		end
	end

	// Permutation table copies
	logic [7:0] perm_mem [NCOPY][2**TABLE_AW];
	logic [TABLE_AW-1:0] rd_addr [NCOPY];
	logic [7:0]          rd_data [NCOPY];

	always_ff @(posedge clk) begin
		if (in_acc && (cmd == CMD_LOAD)) begin
			for (int c = 0; c < NCOPY; c++) begin
				perm_mem[c][table_index] <= table_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCOPY; c++) begin
				rd_data[c] <= perm_mem[c][rd_addr[c]];
			end
		end
	end

	// Stage 1: coordinate sum
	logic signed [31:0] x_s1, y_s1;
	logic signed [32:0] sum_s1;
	// Stage 2: skew offset
	logic signed [31:0] x_s2, y_s2;
	logic signed [32:0] skew_s2;
	logic signed [64:0] skew_prod;
	// Stage 3: cell and in-cell position, inner lookups
	logic signed [33:0] xs, ys;
	logic [7:0]         ii_s3, ii_s4;
	logic [29:0]        u_s3, v_s3;
	// Stage 4: unskewed first-corner offset, inner lookups carried along
	logic [30:0]        uv;
	logic [60:0]        ush_prod;
	logic [28:0]        ush;
	logic signed [31:0] x0_s4, y0_s4;
	logic [7:0]         pj0_s4, pj1_s4;
	// Stage 5: corner offsets, outer lookups
	logic               mid_x;
	logic signed [31:0] x0_s5, y0_s5, x1_s5, y1_s5, x2_s5, y2_s5;
	// Corner terms and sum
	logic signed [31:0] term0, term1, term2;
	logic signed [33:0] sum_s10;
	logic signed [40:0] scaled, rounded, res;

	assign skew_prod = sum_s1 * SKEW_Q32;
	assign xs = 34'(x_s2) + 34'(skew_s2);
	assign ys = 34'(y_s2) + 34'(skew_s2);
	assign uv = 31'(u_s3) + 31'(v_s3);
	assign ush_prod = 61'(uv) * 61'(UNSKEW_Q32);
	assign ush = ush_prod[60:32];
	assign mid_x = x0_s4 > y0_s4;

	// Inner lookups use the cell row; outer lookups add the cell column
	always_comb begin
		rd_addr[0] = ys[COORD_FRAC_BITS+7:COORD_FRAC_BITS];
		rd_addr[1] = ys[COORD_FRAC_BITS+7:COORD_FRAC_BITS] + 8'd1;
		rd_addr[2] = ii_s4 + pj0_s4;
		rd_addr[3] = ii_s4 + 8'(mid_x) + (mid_x ? pj0_s4 : pj1_s4);
		rd_addr[4] = ii_s4 + 8'd1 + pj1_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_coord;
			y_s1    <= y_coord;
			sum_s1  <= 33'(x_coord) + 33'(y_coord);

			x_s2    <= x_s1;
			y_s2    <= y_s1;
			skew_s2 <= skew_prod[64:32];

			ii_s3   <= xs[COORD_FRAC_BITS+7:COORD_FRAC_BITS];
			u_s3    <= {xs[COORD_FRAC_BITS-1:0], {(30-COORD_FRAC_BITS){1'b0}}};
			v_s3    <= {ys[COORD_FRAC_BITS-1:0], {(30-COORD_FRAC_BITS){1'b0}}};

			ii_s4   <= ii_s3;
			pj0_s4  <= rd_data[0];
			pj1_s4  <= rd_data[1];
			x0_s4   <= $signed({2'b00, u_s3}) - $signed({3'b000, ush});
			y0_s4   <= $signed({2'b00, v_s3}) - $signed({3'b000, ush});

			x0_s5   <= x0_s4;
			y0_s5   <= y0_s4;
			x1_s5   <= x0_s4 - (mid_x ? ONE_Q30 : 32'sd0) + UNSKEW_Q30;
			y1_s5   <= y0_s4 - (mid_x ? 32'sd0 : ONE_Q30) + UNSKEW_Q30;
			x2_s5   <= x0_s4 - ONE_Q30 + (UNSKEW_Q30 <<< 1);
			y2_s5   <= y0_s4 - ONE_Q30 + (UNSKEW_Q30 <<< 1);

			sum_s10 <= 34'(term0) + 34'(term1) + 34'(term2);
			noise_value <= res[15:0];
		end
	end

	snz_corner u_corner0 (.clk(clk), .en(en), .dx(x0_s5), .dy(y0_s5),
		.perm_val(rd_data[2]), .term(term0));
	snz_corner u_corner1 (.clk(clk), .en(en), .dx(x1_s5), .dy(y1_s5),
		.perm_val(rd_data[3]), .term(term1));
	snz_corner u_corner2 (.clk(clk), .en(en), .dx(x2_s5), .dy(y2_s5),
		.perm_val(rd_data[4]), .term(term2));

	// Scale by 70, round half up, clamp
	always_comb begin
		scaled  = (41'(sum_s10) <<< 6) + (41'(sum_s10) <<< 2) + (41'(sum_s10) <<< 1);
		rounded = (scaled + RND_C) >>> RND_SH;
		res     = rounded;
		if (rounded > HI_C) begin
			res = HI_C;
		end else if (rounded < LO_C) begin
			res = LO_C;
		end
	end

	// Loads only enter an empty pipeline
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (cmd == CMD_LOAD)) |-> (vld_q == '0))
		else $error("load accepted with evaluates in flight");

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(noise_value)))
		else $error("stalled result changed");

	// Results stay in the clamp range
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((41'(noise_value) <= HI_C) && (41'(noise_value) >= LO_C)))
		else $error("noise result out of range");

endmodule
